// ===== design/cbrm_pkg.sv =====
package cbrm_pkg;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_COMMAND = 3'd1,
    OP_BUSOFF  = 3'd2,
    OP_TX_CONF = 3'd3,
    OP_SLEEP   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    CFG_FAST_TRY_TICKS  = 2'd0,
    CFG_FAST_TRY_LIMIT  = 2'd1,
    CFG_SLOW_TRY_TICKS  = 2'd2,
    CFG_SLOW_WAIT_TICKS = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    MAIN_INACTIVE = 1'b0,
    MAIN_ACTIVE   = 1'b1
  } main_e;

  typedef enum logic [1:0] {
    SUB_INACTIVE_IDLE = 2'd0,
    SUB_ACTIVE_NORMAL = 2'd1,
    SUB_ACTIVE_BUSOFF = 2'd2
  } sub_e;

  typedef enum logic [1:0] {
    PH_NONE  = 2'd0,
    PH_QUICK = 2'd1,
    PH_SLOW  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    SP_NONE = 2'd0,
    SP_TRY  = 2'd1,
    SP_WAIT = 2'd2
  } subph_e;

  // The pending command keeps the raw request, so the unused code is stored too.
  localparam logic [1:0] CMD_NONE        = 2'd0;
  localparam logic [1:0] CMD_GO_ACTIVE   = 2'd1;
  localparam logic [1:0] CMD_GO_INACTIVE = 2'd2;

  localparam logic [1:0] COM_UNSET     = 2'd0;
  localparam logic [1:0] COM_SEND_RECV = 2'd1;
  localparam logic [1:0] COM_RECV_ONLY = 2'd2;

  localparam logic [15:0] FAST_TRY_TICKS_RST  = 16'd10;
  localparam logic [15:0] FAST_TRY_LIMIT_RST  = 16'd5;
  localparam logic [15:0] SLOW_TRY_TICKS_RST  = 16'd200;
  localparam logic [15:0] SLOW_WAIT_TICKS_RST = 16'd20;

  typedef struct packed {
    logic [15:0] fast_try_ticks;
    logic [15:0] fast_try_limit;
    logic [15:0] slow_try_ticks;
    logic [15:0] slow_wait_ticks;
  } cfg_t;

  typedef struct packed {
    op_e        op;
    logic       channel;
    logic [1:0] command;
    logic [1:0] still_off_mask;
  } in_item_t;

  typedef struct packed {
    logic [1:0] recovery_start_mask;
    logic [1:0] reenable_mask;
    logic       fault_raised;
    logic       fault_cleared;
    logic       woke;
    logic       slept;
    logic       is_inactive;
    logic       is_busoff;
    logic [1:0] com_mode;
    logic       sleep_wanted;
  } out_item_t;

  // Per-channel controls from the mode logic.
  typedef struct packed {
    logic step;
    logic tick_run;
    logic start;
    logic clear;
    logic still_off;
  } chan_ctl_t;

  typedef struct packed {
    logic start;
    logic reen;
    logic fault;
    logic busy;
  } chan_sts_t;

endpackage

// ===== design/cbrm_in_if.sv =====
interface cbrm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic       channel;
  logic [1:0] command;
  logic [1:0] still_off_mask;

  modport source (output valid, output op, output channel, output command,
                  output still_off_mask, input ready);
  modport sink (input valid, input op, input channel, input command,
                input still_off_mask, output ready);
endinterface

// ===== design/cbrm_out_if.sv =====
interface cbrm_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] recovery_start_mask;
  logic [1:0] reenable_mask;
  logic       fault_raised;
  logic       fault_cleared;
  logic       woke;
  logic       slept;
  logic       is_inactive;
  logic       is_busoff;
  logic [1:0] com_mode;
  logic       sleep_wanted;

  modport source (output valid, output recovery_start_mask, output reenable_mask,
                  output fault_raised, output fault_cleared, output woke,
                  output slept, output is_inactive, output is_busoff,
                  output com_mode, output sleep_wanted, input ready);
  modport sink (input valid, input recovery_start_mask, input reenable_mask,
                input fault_raised, input fault_cleared, input woke,
                input slept, input is_inactive, input is_busoff,
                input com_mode, input sleep_wanted, output ready);
endinterface

// ===== design/cbrm_cfg_if.sv =====
interface cbrm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/cbrm_chan.sv =====
module cbrm_chan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cbrm_pkg::chan_ctl_t ctl_i,
  input  cbrm_pkg::cfg_t      cfg_i,
  output cbrm_pkg::chan_sts_t sts_o
);
  import cbrm_pkg::*;

  phase_e      phase_q, phase_d;
  subph_e      subph_q, subph_d;
  logic [15:0] tick_q, tick_d;
  logic [15:0] try_q, try_d;
  logic [15:0] tick_inc;
  logic [15:0] try_inc;

  // Both counters saturate rather than wrap.
  assign tick_inc = (tick_q == 16'hFFFF) ? tick_q : tick_q + 16'd1;
  assign try_inc  = (try_q == 16'hFFFF) ? try_q : try_q + 16'd1;

  always_comb begin
    phase_d = phase_q;
    subph_d = subph_q;
    tick_d  = tick_q;
    try_d   = try_q;
    sts_o   = '0;
    if (ctl_i.clear) begin
      if (phase_q != PH_NONE) begin
        phase_d = PH_NONE;
        subph_d = SP_NONE;
        tick_d  = '0;
        try_d   = '0;
      end
    end else if (ctl_i.start) begin
      tick_d = '0;
      case (phase_q)
        PH_NONE: begin
          if (subph_q == SP_NONE) begin
            try_d   = '0;
            subph_d = SP_TRY;
            phase_d = PH_QUICK;
          end
        end
        PH_QUICK, PH_SLOW: begin
          if (subph_q == SP_NONE) begin
            subph_d = SP_TRY;
          end
        end
        default: ;
      endcase
    end else if (ctl_i.tick_run) begin
      case (phase_q)
        PH_QUICK: begin
          if (subph_q == SP_TRY) begin
            tick_d = tick_inc;
            if (tick_inc >= cfg_i.fast_try_ticks) begin
              tick_d      = '0;
              sts_o.start = 1'b1;
              try_d       = try_inc;
              if (try_inc >= cfg_i.fast_try_limit) begin
                try_d       = '0;
                phase_d     = PH_SLOW;
                sts_o.fault = 1'b1;
              end
            end
          end
        end
        PH_SLOW: begin
          case (subph_q)
            SP_TRY: begin
              tick_d = tick_inc;
              if (tick_inc >= cfg_i.slow_try_ticks) begin
                tick_d      = '0;
                sts_o.start = 1'b1;
                subph_d     = SP_WAIT;
              end
            end
            SP_WAIT: begin
              tick_d = tick_inc;
              // With the controller no longer off, simply start another wait.
              if (tick_inc >= cfg_i.slow_wait_ticks) begin
                tick_d = '0;
                if (ctl_i.still_off) begin
                  sts_o.reen = 1'b1;
                  subph_d    = SP_TRY;
                  try_d      = try_inc;
                end
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    sts_o.busy = (phase_d != PH_NONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_NONE;
      subph_q <= SP_NONE;
      tick_q  <= '0;
      try_q   <= '0;
    end else if (ctl_i.step) begin
      phase_q <= phase_d;
      subph_q <= subph_d;
      tick_q  <= tick_d;
      try_q   <= try_d;
    end
  end

endmodule

// ===== design/can_busoff_recovery_manager_core.sv =====
// CAN bus-off recovery manager.
// Words arrive on in_i (tick, command request, bus-off indication, transmit
// confirmation, go to sleep) and every accepted word yields exactly one result
// word on out_o with the action pulses and the mode flags after that word.
// cfg_i writes the four timing registers by index; it is always ready. It must
// only be written while no word is in flight; the block does not enforce this.
// A word accepted on in_i is captured in the input register and is processed
// against the mode and recovery state once the output register is free or being
// taken, which loads its result into the output register. One word is taken
// per cycle while the receiver keeps taking results.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more word; input ready falls only once both
// registers are full and the output is not being taken.
// Reset empties both registers, loads the default timing registers, sets the
// main mode active with the idle sub mode and clears all channel recovery.
module can_busoff_recovery_manager_core #(
  parameter int CHANNELS = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cbrm_in_if.sink    in_i,
  cbrm_out_if.source out_o,
  cbrm_cfg_if.sink   cfg_i
);
  import cbrm_pkg::*;

  cfg_t      cfg_q;
  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q, out_d;
  logic      fire;

  main_e      main_q, main_d;
  sub_e       sub_q, sub_d;
  logic [1:0] pend_q, pend_d;
  logic       sleep_q, sleep_d;
  logic [1:0] com_q, com_d;

  logic      tick_run;
  logic      start_req;
  logic      clear_req;
  chan_ctl_t ctl [CHANNELS];
  chan_sts_t sts [CHANNELS];

  assign fire        = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || fire;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fast_try_ticks  <= FAST_TRY_TICKS_RST;
      cfg_q.fast_try_limit  <= FAST_TRY_LIMIT_RST;
      cfg_q.slow_try_ticks  <= SLOW_TRY_TICKS_RST;
      cfg_q.slow_wait_ticks <= SLOW_WAIT_TICKS_RST;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_FAST_TRY_TICKS:  cfg_q.fast_try_ticks  <= cfg_i.data;
        CFG_FAST_TRY_LIMIT:  cfg_q.fast_try_limit  <= cfg_i.data;
        CFG_SLOW_TRY_TICKS:  cfg_q.slow_try_ticks  <= cfg_i.data;
        CFG_SLOW_WAIT_TICKS: cfg_q.slow_wait_ticks <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q.op             <= op_e'(in_i.op);
      in_q.channel        <= in_i.channel;
      in_q.command        <= in_i.command;
      in_q.still_off_mask <= in_i.still_off_mask;
    end
  end

  // Mode handling for the word in the input register.
  always_comb begin
    main_d    = main_q;
    sub_d     = sub_q;
    pend_d    = pend_q;
    sleep_d   = sleep_q;
    com_d     = com_q;
    tick_run  = 1'b0;
    start_req = 1'b0;
    clear_req = 1'b0;
    out_d     = '0;
    case (in_q.op)
      OP_TICK: begin
        if (main_q == MAIN_INACTIVE) begin
          if (pend_q == CMD_GO_ACTIVE) begin
            pend_d     = CMD_NONE;
            com_d      = COM_SEND_RECV;
            sleep_d    = 1'b0;
            main_d     = MAIN_ACTIVE;
            sub_d      = SUB_ACTIVE_NORMAL;
            out_d.woke = 1'b1;
          end
        end else begin
          if (pend_q == CMD_GO_ACTIVE) begin
            pend_d  = CMD_NONE;
            sleep_d = 1'b0;
          end
          if (sub_q == SUB_ACTIVE_BUSOFF) begin
            if (pend_q == CMD_GO_INACTIVE) begin
              pend_d  = CMD_NONE;
              sleep_d = 1'b1;
            end
            tick_run = 1'b1;
          end
        end
      end
      OP_COMMAND: begin
        pend_d = in_q.command;
      end
      OP_BUSOFF: begin
        // A second bus-off while already recovering is ignored.
        if (sub_q != SUB_ACTIVE_BUSOFF) begin
          main_d    = MAIN_ACTIVE;
          sub_d     = SUB_ACTIVE_BUSOFF;
          start_req = 1'b1;
        end
      end
      OP_TX_CONF: begin
        out_d.fault_cleared = 1'b1;
        if (sub_q == SUB_ACTIVE_BUSOFF) begin
          clear_req = 1'b1;
          main_d    = MAIN_ACTIVE;
          sub_d     = SUB_ACTIVE_NORMAL;
        end
      end
      OP_SLEEP: begin
        pend_d      = CMD_NONE;
        main_d      = MAIN_INACTIVE;
        sub_d       = SUB_INACTIVE_IDLE;
        sleep_d     = 1'b1;
        com_d       = COM_RECV_ONLY;
        out_d.slept = 1'b1;
      end
      default: ;
    endcase

    out_d.is_inactive  = (main_d == MAIN_INACTIVE);
    out_d.is_busoff    = (main_d != MAIN_ACTIVE) || (sub_d == SUB_ACTIVE_BUSOFF);
    out_d.com_mode     = com_d;
    out_d.sleep_wanted = sleep_d;
    for (int i = 0; i < CHANNELS; i++) begin
      out_d.recovery_start_mask[i] = sts[i].start;
      out_d.reenable_mask[i]       = sts[i].reen;
      if (sts[i].fault) begin
        out_d.fault_raised = 1'b1;
      end
      if (sts[i].busy) begin
        out_d.is_busoff = 1'b1;
      end
    end
  end

  for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
    logic sel;

    assign sel = (in_q.channel == 1'(g));

    assign ctl[g].step      = fire;
    assign ctl[g].tick_run  = tick_run;
    assign ctl[g].start     = start_req && sel;
    assign ctl[g].clear     = clear_req && sel;
    assign ctl[g].still_off = in_q.still_off_mask[g];

    cbrm_chan u_chan (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl[g]),
      .cfg_i  (cfg_q),
      .sts_o  (sts[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_q      <= MAIN_ACTIVE;
      sub_q       <= SUB_INACTIVE_IDLE;
      pend_q      <= CMD_NONE;
      sleep_q     <= 1'b0;
      com_q       <= COM_UNSET;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        main_q  <= main_d;
        sub_q   <= sub_d;
        pend_q  <= pend_d;
        sleep_q <= sleep_d;
        com_q   <= com_d;
      end
      if (!out_valid_q || out_o.ready) begin
        out_valid_q <= fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid               = out_valid_q;
  assign out_o.recovery_start_mask = out_q.recovery_start_mask;
  assign out_o.reenable_mask       = out_q.reenable_mask;
  assign out_o.fault_raised        = out_q.fault_raised;
  assign out_o.fault_cleared       = out_q.fault_cleared;
  assign out_o.woke                = out_q.woke;
  assign out_o.slept               = out_q.slept;
  assign out_o.is_inactive         = out_q.is_inactive;
  assign out_o.is_busoff           = out_q.is_busoff;
  assign out_o.com_mode            = out_q.com_mode;
  assign out_o.sleep_wanted        = out_q.sleep_wanted;

  a_in_stall_only_when_full : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> in_valid_q && out_valid_q && !out_o.ready
  ) else $error("input stalled while the result register could move");

  a_start_reen_exclusive : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.recovery_start_mask & out_q.reenable_mask) == 2'b00
  ) else $error("recovery start and re-enable on the same channel");

  a_slept_status : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    fire && in_q.op == OP_SLEEP |=> out_q.slept && out_q.is_inactive &&
      out_q.com_mode == COM_RECV_ONLY && out_q.is_busoff
  ) else $error("sleep word did not report the sleeping state");

  a_woke_status : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.woke |-> !out_q.is_inactive &&
      out_q.com_mode == COM_SEND_RECV && !out_q.sleep_wanted
  ) else $error("wake pulse without the active state");

endmodule

// ===== bench/busoff_recovery_checker.sv =====
`timescale 1ns / 1ps

module busoff_recovery_checker
  import cbrm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  cbrm_in_if          in_mon_i,
  cbrm_out_if         out_mon_i,
  cbrm_cfg_if         cfg_mon_i,
  output int unsigned fail_o,
  output int unsigned outstanding_o,
  output int unsigned checked_o,
  output int unsigned faults_o,
  output int unsigned reenables_o
);

  localparam int CHANNELS = 2;

  // Shadow copy of the timing registers and of the mode and recovery state.
  cfg_t        timing;
  main_e       main_mode;
  sub_e        sub_mode;
  logic [1:0]  pend_cmd;
  logic        sleep_flag;
  logic [1:0]  comm_mode;
  phase_e      phase    [CHANNELS];
  subph_e      subph    [CHANNELS];
  logic [15:0] tick_cnt [CHANNELS];
  logic [15:0] try_cnt  [CHANNELS];

  out_item_t   exp_status_q[$];
  in_item_t    in_w;
  out_item_t   seen_w;
  out_item_t   want_w;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // Applies one input word to the shadow state and returns the status word it yields.
  function automatic out_item_t predict_status_word(input in_item_t w);
    out_item_t r;
    int        c;
    r = '0;
    case (w.op)
      OP_TICK: begin
        if (main_mode == MAIN_INACTIVE) begin
          if (pend_cmd == CMD_GO_ACTIVE) begin
            pend_cmd   = CMD_NONE;
            comm_mode  = COM_SEND_RECV;
            sleep_flag = 1'b0;
            main_mode  = MAIN_ACTIVE;
            sub_mode   = SUB_ACTIVE_NORMAL;
            r.woke     = 1'b1;
          end
        end else begin
          if (pend_cmd == CMD_GO_ACTIVE) begin
            pend_cmd   = CMD_NONE;
            sleep_flag = 1'b0;
          end
          if (sub_mode == SUB_ACTIVE_BUSOFF) begin
            if (pend_cmd == CMD_GO_INACTIVE) begin
              pend_cmd   = CMD_NONE;
              sleep_flag = 1'b1;
            end
            for (c = 0; c < CHANNELS; c++) begin
              if (phase[c] == PH_QUICK) begin
                if (subph[c] == SP_TRY) begin
                  tick_cnt[c] = sat_inc(tick_cnt[c]);
                  if (tick_cnt[c] >= timing.fast_try_ticks) begin
                    tick_cnt[c] = '0;
                    r.recovery_start_mask[c] = 1'b1;
                    try_cnt[c] = sat_inc(try_cnt[c]);
                    if (try_cnt[c] >= timing.fast_try_limit) begin
                      try_cnt[c]     = '0;
                      phase[c]       = PH_SLOW;
                      r.fault_raised = 1'b1;
                    end
                  end
                end
              end else if (phase[c] == PH_SLOW) begin
                if (subph[c] == SP_TRY) begin
                  tick_cnt[c] = sat_inc(tick_cnt[c]);
                  if (tick_cnt[c] >= timing.slow_try_ticks) begin
                    tick_cnt[c] = '0;
                    r.recovery_start_mask[c] = 1'b1;
                    subph[c] = SP_WAIT;
                  end
                end else if (subph[c] == SP_WAIT) begin
                  tick_cnt[c] = sat_inc(tick_cnt[c]);
                  if (tick_cnt[c] >= timing.slow_wait_ticks) begin
                    tick_cnt[c] = '0;
                    // Without the still-off flag the channel simply waits another period.
                    if (w.still_off_mask[c]) begin
                      r.reenable_mask[c] = 1'b1;
                      subph[c]   = SP_TRY;
                      try_cnt[c] = sat_inc(try_cnt[c]);
                    end
                  end
                end
              end
            end
          end
        end
      end
      OP_COMMAND: pend_cmd = w.command;
      OP_BUSOFF: begin
        if (sub_mode != SUB_ACTIVE_BUSOFF) begin
          main_mode = MAIN_ACTIVE;
          sub_mode  = SUB_ACTIVE_BUSOFF;
          tick_cnt[w.channel] = '0;
          if (phase[w.channel] == PH_NONE) begin
            if (subph[w.channel] == SP_NONE) begin
              try_cnt[w.channel] = '0;
              subph[w.channel]   = SP_TRY;
              phase[w.channel]   = PH_QUICK;
            end
          end else if (subph[w.channel] == SP_NONE) begin
            subph[w.channel] = SP_TRY;
          end
        end
      end
      OP_TX_CONF: begin
        r.fault_cleared = 1'b1;
        if (sub_mode == SUB_ACTIVE_BUSOFF) begin
          if (phase[w.channel] != PH_NONE) begin
            tick_cnt[w.channel] = '0;
            try_cnt[w.channel]  = '0;
            subph[w.channel]    = SP_NONE;
            phase[w.channel]    = PH_NONE;
          end
          main_mode = MAIN_ACTIVE;
          sub_mode  = SUB_ACTIVE_NORMAL;
        end
      end
      OP_SLEEP: begin
        pend_cmd   = CMD_NONE;
        main_mode  = MAIN_INACTIVE;
        sub_mode   = SUB_INACTIVE_IDLE;
        sleep_flag = 1'b1;
        comm_mode  = COM_RECV_ONLY;
        r.slept    = 1'b1;
      end
      default: ;
    endcase
    r.is_inactive  = (main_mode == MAIN_INACTIVE);
    r.is_busoff    = (main_mode != MAIN_ACTIVE) || (sub_mode == SUB_ACTIVE_BUSOFF);
    for (c = 0; c < CHANNELS; c++) begin
      if (phase[c] != PH_NONE) r.is_busoff = 1'b1;
    end
    r.com_mode     = comm_mode;
    r.sleep_wanted = sleep_flag;
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", fname, exp_v, act_v);
      fail_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing.fast_try_ticks  = FAST_TRY_TICKS_RST;
      timing.fast_try_limit  = FAST_TRY_LIMIT_RST;
      timing.slow_try_ticks  = SLOW_TRY_TICKS_RST;
      timing.slow_wait_ticks = SLOW_WAIT_TICKS_RST;
      main_mode  = MAIN_ACTIVE;
      sub_mode   = SUB_INACTIVE_IDLE;
      pend_cmd   = CMD_NONE;
      sleep_flag = 1'b0;
      comm_mode  = COM_UNSET;
      for (int c = 0; c < CHANNELS; c++) begin
        phase[c]    = PH_NONE;
        subph[c]    = SP_NONE;
        tick_cnt[c] = '0;
        try_cnt[c]  = '0;
      end
      exp_status_q.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_mon_i.valid && cfg_mon_i.ready) begin
        case (cfg_mon_i.index)
          CFG_FAST_TRY_TICKS:  timing.fast_try_ticks  = cfg_mon_i.data;
          CFG_FAST_TRY_LIMIT:  timing.fast_try_limit  = cfg_mon_i.data;
          CFG_SLOW_TRY_TICKS:  timing.slow_try_ticks  = cfg_mon_i.data;
          CFG_SLOW_WAIT_TICKS: timing.slow_wait_ticks = cfg_mon_i.data;
          default: ;
        endcase
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        seen_w.recovery_start_mask = out_mon_i.recovery_start_mask;
        seen_w.reenable_mask       = out_mon_i.reenable_mask;
        seen_w.fault_raised        = out_mon_i.fault_raised;
        seen_w.fault_cleared       = out_mon_i.fault_cleared;
        seen_w.woke                = out_mon_i.woke;
        seen_w.slept               = out_mon_i.slept;
        seen_w.is_inactive         = out_mon_i.is_inactive;
        seen_w.is_busoff           = out_mon_i.is_busoff;
        seen_w.com_mode            = out_mon_i.com_mode;
        seen_w.sleep_wanted        = out_mon_i.sleep_wanted;
        if (exp_status_q.size() == 0) begin
          $error("status word arrived with no word outstanding");
          fail_o++;
        end else begin
          want_w = exp_status_q.pop_front();
          check_field("recovery_start_mask", 16'(want_w.recovery_start_mask),
                      16'(seen_w.recovery_start_mask));
          check_field("reenable_mask", 16'(want_w.reenable_mask),
                      16'(seen_w.reenable_mask));
          check_field("fault_raised", 16'(want_w.fault_raised),
                      16'(seen_w.fault_raised));
          check_field("fault_cleared", 16'(want_w.fault_cleared),
                      16'(seen_w.fault_cleared));
          check_field("woke", 16'(want_w.woke), 16'(seen_w.woke));
          check_field("slept", 16'(want_w.slept), 16'(seen_w.slept));
          check_field("is_inactive", 16'(want_w.is_inactive),
                      16'(seen_w.is_inactive));
          check_field("is_busoff", 16'(want_w.is_busoff), 16'(seen_w.is_busoff));
          check_field("com_mode", 16'(want_w.com_mode), 16'(seen_w.com_mode));
          check_field("sleep_wanted", 16'(want_w.sleep_wanted),
                      16'(seen_w.sleep_wanted));
          checked_o++;
          if (want_w.fault_raised) faults_o++;
          if (want_w.reenable_mask != 2'b00) reenables_o++;
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        in_w = {in_mon_i.op, in_mon_i.channel, in_mon_i.command, in_mon_i.still_off_mask};
        exp_status_q.push_back(predict_status_word(in_w));
      end
      outstanding_o <= exp_status_q.size();
    end
  end

endmodule

// ===== bench/can_busoff_recovery_manager_core_tb.sv =====
`timescale 1ns / 1ps

module can_busoff_recovery_manager_core_tb;
  import cbrm_pkg::*;

  // Operation and command codes that the package leaves without a name.
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
  localparam logic [1:0] CMD_SPARE      = 2'd3;

  localparam int unsigned HOLD_CYCLES       = 64;
  localparam int unsigned CYCLE_LIMIT       = 500000;
  localparam int unsigned WORDS_PER_SETTING = 88;

  logic        clk;
  logic        rst_n;
  logic        calm;
  logic        hold_req;
  int unsigned cycles;
  int unsigned words_sent;
  int unsigned settings_run;
  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned checked;
  int unsigned faults_seen;
  int unsigned reenables_seen;

  cbrm_in_if  in_ch ();
  cbrm_out_if out_ch ();
  cbrm_cfg_if cfg_ch ();

  can_busoff_recovery_manager_core u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  busoff_recovery_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_mon_i      (in_ch),
    .out_mon_i     (out_ch),
    .cfg_mon_i     (cfg_ch),
    .fail_o        (fail_count),
    .outstanding_o (outstanding),
    .checked_o     (checked),
    .faults_o      (faults_seen),
    .reenables_o   (reenables_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // Mostly short stalls, now and then a long one.
  function automatic int unsigned stall_len();
    if ($urandom_range(0, 4) != 0) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver: random back-pressure, none during calm stretches, and one long
  // hold-off on request.
  initial begin
    bit held;
    held         = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) < 3) begin
        out_ch.ready <= 1'b0;
        repeat (stall_len()) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic [2:0] op, input logic chan, input logic [1:0] cmd,
                           input logic [1:0] mask);
    int unsigned gap;
    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : stall_len();
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.op             <= op;
    in_ch.channel        <= chan;
    in_ch.command        <= cmd;
    in_ch.still_off_mask <= mask;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  task automatic send_random_word();
    int unsigned r;
    logic [2:0]  op;
    logic [1:0]  cmd;
    r = $urandom_range(0, 99);
    if (r < 40)      op = OP_TICK;
    else if (r < 55) op = OP_BUSOFF;
    else if (r < 67) op = OP_TX_CONF;
    else if (r < 85) op = OP_COMMAND;
    else if (r < 94) op = OP_SLEEP;
    else             op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    r = $urandom_range(0, 9);
    if (r < 4)      cmd = CMD_GO_ACTIVE;
    else if (r < 7) cmd = CMD_GO_INACTIVE;
    else if (r < 9) cmd = CMD_NONE;
    else            cmd = CMD_SPARE;
    send_word(op, 1'($urandom_range(0, 1)), cmd, 2'($urandom_range(0, 3)));
  endtask

  // Stops offering words and waits until every status word has been taken.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic write_timing(input logic [15:0] f_ticks, input logic [15:0] f_limit,
                              input logic [15:0] s_ticks, input logic [15:0] s_wait);
    wait_idle();
    write_reg(CFG_FAST_TRY_TICKS, f_ticks);
    write_reg(CFG_FAST_TRY_LIMIT, f_limit);
    write_reg(CFG_SLOW_TRY_TICKS, s_ticks);
    write_reg(CFG_SLOW_WAIT_TICKS, s_wait);
    settings_run++;
  endtask

  // Mostly bus-off episodes: an indication, a run of ticks with some noise
  // mixed in, and usually a transmit confirmation to close it.
  task automatic run_setting(input logic [15:0] f_ticks, input logic [15:0] f_limit,
                             input logic [15:0] s_ticks, input logic [15:0] s_wait,
                             input bit long_runs, input bit with_hold, input bit with_pause);
    int unsigned goal;
    int unsigned len;
    logic [1:0]  mask;
    bit          hold_done;
    bit          pause_done;
    write_timing(f_ticks, f_limit, s_ticks, s_wait);
    goal       = words_sent + WORDS_PER_SETTING;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    while (words_sent < goal) begin
      calm = ($urandom_range(0, 3) == 0);
      if (with_hold && !hold_done && words_sent + 50 >= goal) begin
        hold_done = 1'b1;
        calm      = 1'b1;
        hold_req  = 1'b1;
      end
      if (with_pause && !pause_done && words_sent + 50 >= goal) begin
        pause_done = 1'b1;
        wait_idle();
      end
      if ($urandom_range(0, 9) < 7) begin
        send_word(OP_BUSOFF, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                  2'($urandom_range(0, 3)));
        if (long_runs && $urandom_range(0, 1) == 0) len = $urandom_range(55, 260);
        else len = $urandom_range(3, 40);
        repeat (len) begin
          if ($urandom_range(0, 9) == 0) begin
            send_random_word();
          end else begin
            mask = ($urandom_range(0, 3) == 0) ? 2'b00 : 2'($urandom_range(1, 3));
            send_word(OP_TICK, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), mask);
          end
        end
        if ($urandom_range(0, 4) != 0) begin
          send_word(OP_TX_CONF, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                    2'($urandom_range(0, 3)));
        end
      end else begin
        repeat ($urandom_range(1, 6)) send_random_word();
      end
    end
  endtask

  initial begin
    rst_n                = 1'b0;
    calm                 = 1'b0;
    hold_req             = 1'b0;
    words_sent           = 0;
    settings_run         = 0;
    in_ch.valid          = 1'b0;
    in_ch.op             = OP_TICK;
    in_ch.channel        = 1'b0;
    in_ch.command        = CMD_NONE;
    in_ch.still_off_mask = 2'b00;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = CFG_FAST_TRY_TICKS;
    cfg_ch.data          = 16'd0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Mode handling under the reset timing.
    send_word(OP_TICK, 1'b0, CMD_NONE, 2'b00);
    send_word(OP_SPARE_FIRST, 1'b0, CMD_NONE, 2'b00);
    send_word(OP_SPARE_LAST, 1'b1, CMD_SPARE, 2'b11);
    send_word(OP_COMMAND, 1'b1, CMD_SPARE, 2'b11);
    send_word(OP_TICK, 1'b1, CMD_SPARE, 2'b11);
    send_word(OP_COMMAND, 1'b0, CMD_GO_INACTIVE, 2'b00);
    send_word(OP_TICK, 1'b0, CMD_NONE, 2'b00);
    send_word(OP_BUSOFF, 1'b1, CMD_NONE, 2'b00);
    // A second bus-off while already in the bus-off sub mode is ignored.
    send_word(OP_BUSOFF, 1'b0, CMD_NONE, 2'b00);
    send_word(OP_TICK, 1'b0, CMD_NONE, 2'b11);
    send_word(OP_TX_CONF, 1'b0, CMD_NONE, 2'b00);
    send_word(OP_TX_CONF, 1'b1, CMD_NONE, 2'b00);
    send_word(OP_BUSOFF, 1'b0, CMD_NONE, 2'b00);
    send_word(OP_SLEEP, 1'b1, CMD_GO_ACTIVE, 2'b11);
    send_word(OP_TICK, 1'b0, CMD_NONE, 2'b00);
    send_word(OP_COMMAND, 1'b0, CMD_GO_ACTIVE, 2'b00);
    send_word(OP_TICK, 1'b0, CMD_NONE, 2'b00);
    send_word(OP_COMMAND, 1'b1, CMD_GO_ACTIVE, 2'b00);
    send_word(OP_TICK, 1'b0, CMD_NONE, 2'b00);

    // A full recovery walk with short periods: quick attempt, fault, slow attempt,
    // a wait without the still-off flag that starts another wait, then a re-enable.
    write_timing(16'd1, 16'd1, 16'd1, 16'd2);
    send_word(OP_BUSOFF, 1'b0, CMD_NONE, 2'b00);
    send_word(OP_TICK, 1'b0, CMD_NONE, 2'b00);
    send_word(OP_TICK, 1'b0, CMD_NONE, 2'b00);
    send_word(OP_TICK, 1'b0, CMD_NONE, 2'b10);
    send_word(OP_TICK, 1'b0, CMD_NONE, 2'b10);
    send_word(OP_TICK, 1'b0, CMD_NONE, 2'b01);
    send_word(OP_TICK, 1'b0, CMD_NONE, 2'b01);
    send_word(OP_TX_CONF, 1'b0, CMD_NONE, 2'b00);

    run_setting(16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b1);
    run_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    run_setting(16'd2, 16'd3, 16'd4, 16'd2, 1'b0, 1'b1, 1'b0);
    run_setting(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)), 1'b0, 1'b0, 1'b0);
    run_setting(FAST_TRY_TICKS_RST, FAST_TRY_LIMIT_RST, SLOW_TRY_TICKS_RST,
                SLOW_WAIT_TICKS_RST, 1'b1, 1'b0, 1'b0);
    run_setting(16'd1, 16'hFFFF, 16'd1, 16'd1, 1'b0, 1'b0, 1'b0);
    run_setting(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)), 1'b0, 1'b0, 1'b0);
    run_setting(16'd1, 16'd1, 16'd1, 16'd1, 1'b0, 1'b0, 1'b0);

    calm = 1'b0;
    wait_idle();
    repeat (8) @(posedge clk);

    $display("Sent %0d words under %0d timing settings; %0d status words compared.",
             words_sent, settings_run, checked);
    $display("Quick recovery gave up %0d times and bus-off handling was re-enabled %0d times.",
             faults_seen, reenables_seen);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
